@@ src/sahs_pkg.sv @@
// Package for the binned split-cost sweep: controller state codes and the
// command and status structs between controller and datapath. No dependencies.
package sahs_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SUFFIX,
    ST_SFX_WAIT,
    ST_SWEEP_RD,
    ST_SWEEP_AREA,
    ST_SWEEP_COST,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;        // write the input bucket at the fill count
    logic sfx_start;   // clear the suffix accumulator, index = count-1
    logic sfx_step;    // step the suffix pass: read a bucket, or fold it in
    logic sweep_start; // set up the prefix sweep
    logic rd;          // read bucket i+1 and suffix i+1
    logic area;        // compute areas of prefix and right
    logic cost;        // compute cost, compare, advance prefix
    logic finish;      // present the result and clear the registers
  } cmd_t;

  typedef struct packed {
    logic sfx_done;
    logic sweep_done;
    logic few;         // fewer than two buckets stored
  } status_t;

endpackage

@@ src/sahs_ctrl.sv @@
// Controller state machine for the split-cost sweep.
// Depends on sahs_pkg for the state type and the command and status structs.
module sahs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              last_bucket,
  input  logic              out_stall,
  input  sahs_pkg::status_t status,
  output logic              in_stall,
  output logic              out_valid,
  output sahs_pkg::cmd_t    cmd
);
  import sahs_pkg::*;

  state_t state, state_next;
  logic   in_acc;

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:       if (in_acc && last_bucket) state_next = ST_SUFFIX;
      ST_SUFFIX:     state_next = status.sfx_done ? ST_SFX_WAIT : ST_SUFFIX;
      ST_SFX_WAIT:   state_next = status.few ? ST_OUT : ST_SWEEP_RD;
      ST_SWEEP_RD:   state_next = ST_SWEEP_AREA;
      ST_SWEEP_AREA: state_next = ST_SWEEP_COST;
      ST_SWEEP_COST: state_next = status.sweep_done ? ST_OUT : ST_SWEEP_RD;
      ST_OUT:        if (!out_stall) state_next = ST_LOAD;
      default:       state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_acc;
        cmd.sfx_start = in_acc && last_bucket;
      end
      ST_SUFFIX:     cmd.sfx_step = 1'b1;
      ST_SFX_WAIT:   cmd.sweep_start = 1'b1;
      ST_SWEEP_RD:   cmd.rd = 1'b1;
      ST_SWEEP_AREA: cmd.area = 1'b1;
      ST_SWEEP_COST: cmd.cost = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.finish = !out_stall;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_cost_after_area: assert property (@(posedge clk) disable iff (rst)
    cmd.area |=> cmd.cost) else $error("area step not followed by cost");
`endif
endmodule

@@ src/sahs_datapath.sv @@
// Datapath of the split-cost sweep: bucket and suffix memories, union logic,
// area and cost arithmetic and the best-split registers. Depends on sahs_pkg.
module sahs_datapath #(
  parameter int MAX_BUCKETS = 64,
  parameter int CW = 16,
  parameter int EW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sahs_pkg::cmd_t         cmd,
  output sahs_pkg::status_t      status,
  input  logic signed [CW-1:0]   in_lo [3],
  input  logic signed [CW-1:0]   in_hi [3],
  input  logic                   in_empty,
  input  logic [EW-1:0]          in_entry,
  output logic [EW-1:0]          split_entry,
  output logic                   split_found,
  output logic signed [CW-1:0]   u_lo [3],
  output logic signed [CW-1:0]   u_hi [3],
  output logic [42:0]            best_cost
);
  import sahs_pkg::*;

  localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = $clog2(MAX_BUCKETS + 1);
  localparam int BW = 6 * CW + 1;   // packed box: empty, hi[3], lo[3]
  localparam int XW = CW + 1;       // extent width
  localparam int PW = 2 * XW;       // product width
  localparam int AREAW = PW + 3;    // 2*(sum of three products)
  localparam int CSW = AREAW + NW + 1;
  localparam logic [42:0] CMAX = '1;

  typedef logic [BW-1:0] pbox_t;

  logic [BW-1:0] bucket_mem [MAX_BUCKETS];
  logic [EW-1:0] entry_mem [MAX_BUCKETS];
  logic [BW-1:0] sfx_mem [MAX_BUCKETS];

  logic [NW-1:0] count;
  logic [AW-1:0] sfx_idx;
  logic          sfx_rd_vld;
  logic          sfx_last;
  pbox_t         sfx_acc;
  pbox_t         bkt_rd, sfx_rd;
  logic [EW-1:0] ent_rd;
  logic [NW-1:0] sw_i;       // number of buckets on the left side
  pbox_t         prefix;
  logic          found;
  logic [42:0]   best_c;
  logic [EW-1:0] best_e;
  pbox_t         best_b;
  logic [AREAW-1:0] area_l, area_r;
  pbox_t         bucket_mem_first;
  logic [NW-1:0] count_ld;
  logic [CSW-1:0] cost_full;
  logic [42:0]    cost_sat;

  function automatic pbox_t box_union(pbox_t a, pbox_t b);
    pbox_t r;
    logic signed [CW-1:0] al, bl, ah, bh;
    r = '0;
    if (a[BW-1]) r = b;
    else if (b[BW-1]) r = a;
    else begin
      for (int k = 0; k < 3; k++) begin
        al = a[k*CW +: CW]; bl = b[k*CW +: CW];
        ah = a[(3+k)*CW +: CW]; bh = b[(3+k)*CW +: CW];
        r[k*CW +: CW] = (al < bl) ? al : bl;
        r[(3+k)*CW +: CW] = (ah > bh) ? ah : bh;
      end
    end
    return r;
  endfunction

  function automatic logic [XW-1:0] extent(pbox_t b, int k);
    logic signed [XW-1:0] d;
    d = XW'($signed(b[(3+k)*CW +: CW])) - XW'($signed(b[k*CW +: CW]));
    return (d > 0) ? d : '0;
  endfunction

  function automatic logic [AREAW-1:0] area_of(pbox_t b);
    logic [PW-1:0] a0, a1, a2;
    a0 = extent(b, 0) * extent(b, 1);
    a1 = extent(b, 1) * extent(b, 2);
    a2 = extent(b, 2) * extent(b, 0);
    return b[BW-1] ? '0 : AREAW'({(AREAW'(a0) + AREAW'(a1) + AREAW'(a2)), 1'b0});
  endfunction

  // Bucket loading and the suffix pass read/write ports.
  always_ff @(posedge clk) begin
    if (cmd.load && (count < NW'(MAX_BUCKETS))) begin
      bucket_mem[count[AW-1:0]] <= {in_empty, in_hi[2], in_hi[1], in_hi[0],
                                    in_lo[2], in_lo[1], in_lo[0]};
      entry_mem[count[AW-1:0]] <= in_entry;
    end
    if (sfx_rd_vld) sfx_mem[sfx_idx] <= box_union(bkt_rd, sfx_acc);
    bkt_rd <= bucket_mem[cmd.sfx_step ? sfx_idx : sw_i[AW-1:0]];
    sfx_rd <= sfx_mem[sw_i[AW-1:0]];
    ent_rd <= entry_mem[sw_i[AW-1:0]];
  end

  // Bucket zero is copied into a register during the suffix pass for sweep start.
  always_ff @(posedge clk) begin
    if (cmd.sfx_step) bucket_mem_first <= bucket_mem[0];
  end

  assign count_ld = (cmd.load && (count < NW'(MAX_BUCKETS))) ? count + 1'b1 : count;

  always_comb begin
    cost_full = CSW'(area_l) * CSW'(sw_i) + CSW'(area_r) * CSW'(count - sw_i);
    if (CSW > 43) cost_sat = (cost_full > CSW'(CMAX)) ? CMAX : 43'(cost_full);
    else          cost_sat = 43'(cost_full);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      count <= '0;
      sfx_rd_vld <= 1'b0;
      sfx_last <= 1'b0;
      found <= 1'b0;
      best_c <= CMAX;
      best_e <= '0;
      best_b <= {1'b1, {(BW-1){1'b0}}};
      prefix <= {1'b1, {(BW-1){1'b0}}};
      sw_i <= '0;
      sfx_idx <= '0;
    end else begin
      count <= count_ld;
      if (cmd.sfx_start) begin
        sfx_idx <= AW'(count_ld - 1'b1);
        sfx_acc <= {1'b1, {(BW-1){1'b0}}};
        sfx_rd_vld <= 1'b0;
        sfx_last <= 1'b0;
      end else if (cmd.sfx_step) begin
        // Read and fold alternate, so a new bucket is read only after the last is folded.
        if (sfx_rd_vld) begin
          sfx_acc <= box_union(bkt_rd, sfx_acc);
          if (sfx_idx != '0) sfx_idx <= sfx_idx - 1'b1;
          else sfx_last <= 1'b1;
          sfx_rd_vld <= 1'b0;
        end else begin
          sfx_rd_vld <= !sfx_last;
        end
      end
      if (cmd.sweep_start) begin
        sfx_rd_vld <= 1'b0;
        sw_i <= NW'(1);
        prefix <= bucket_mem_first;
      end
      if (cmd.area) begin
        area_l <= area_of(prefix);
        area_r <= area_of(sfx_rd);
      end
      if (cmd.cost) begin
        if (!found || cost_sat < best_c) begin
          found <= 1'b1;
          best_c <= cost_sat;
          best_e <= ent_rd;
          best_b <= box_union(prefix, sfx_rd);
        end
        prefix <= box_union(prefix, bkt_rd);
        sw_i <= sw_i + 1'b1;
      end
    end
  end

  assign status.sfx_done = sfx_last;
  assign status.sweep_done = (sw_i + 1'b1) >= count;
  assign status.few = count < NW'(2);

  assign split_found = found;
  assign split_entry = found ? best_e : '0;
  assign best_cost = found ? best_c : CMAX;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u_lo[k] = (found && !best_b[BW-1]) ? best_b[k*CW +: CW] : '0;
      u_hi[k] = (found && !best_b[BW-1]) ? best_b[(3+k)*CW +: CW] : '0;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(MAX_BUCKETS)) else $error("bucket count overrun");
  a_found_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.cost |=> found) else $error("cost step left no best split");
  a_sweep_idx: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (sw_i < count)) else $error("sweep index past stored buckets");
`endif
endmodule

@@ src/sah_split_cost_sweep.sv @@
// Top level of the binned split-cost sweep: joins controller and datapath.
// Depends on sahs_pkg, sahs_ctrl and sahs_datapath.
//
//   channel | direction | handshake          | payload
//   bucket  | in        | in_valid/in_stall  | box bounds, empty, entry, last
//   result  | out       | out_valid/out_stall| split, union box, cost
//
// Buckets load one per cycle. With n stored buckets, the last bucket starts a
// suffix pass (one memory read and one fold per bucket), a setup step and,
// with two or more buckets stored, a sweep of read, area and cost steps for
// each split point; then the result is offered.
// Reset is synchronous and clears the fill count and best-split registers.
// Input is stalled from the last bucket until the result is taken.
module sah_split_cost_sweep #(
  parameter int MAX_BUCKETS = 64,
  parameter int COORD_WIDTH = 16,
  parameter int ENTRY_INDEX_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] box_min_x,
  input  logic signed [COORD_WIDTH-1:0] box_min_y,
  input  logic signed [COORD_WIDTH-1:0] box_min_z,
  input  logic signed [COORD_WIDTH-1:0] box_max_x,
  input  logic signed [COORD_WIDTH-1:0] box_max_y,
  input  logic signed [COORD_WIDTH-1:0] box_max_z,
  input  logic                          bucket_empty,
  input  logic [ENTRY_INDEX_WIDTH-1:0]  first_entry,
  input  logic                          last_bucket,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ENTRY_INDEX_WIDTH-1:0]  split_entry,
  output logic                          split_found,
  output logic signed [COORD_WIDTH-1:0] union_min_x,
  output logic signed [COORD_WIDTH-1:0] union_min_y,
  output logic signed [COORD_WIDTH-1:0] union_min_z,
  output logic signed [COORD_WIDTH-1:0] union_max_x,
  output logic signed [COORD_WIDTH-1:0] union_max_y,
  output logic signed [COORD_WIDTH-1:0] union_max_z,
  output logic [42:0]                   best_cost
);
  import sahs_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic signed [COORD_WIDTH-1:0] in_lo [3];
  logic signed [COORD_WIDTH-1:0] in_hi [3];
  logic signed [COORD_WIDTH-1:0] u_lo [3];
  logic signed [COORD_WIDTH-1:0] u_hi [3];

  assign in_lo[0] = box_min_x; assign in_lo[1] = box_min_y; assign in_lo[2] = box_min_z;
  assign in_hi[0] = box_max_x; assign in_hi[1] = box_max_y; assign in_hi[2] = box_max_z;
  assign union_min_x = u_lo[0]; assign union_min_y = u_lo[1]; assign union_min_z = u_lo[2];
  assign union_max_x = u_hi[0]; assign union_max_y = u_hi[1]; assign union_max_z = u_hi[2];

  sahs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .last_bucket, .out_stall, .status,
    .in_stall, .out_valid, .cmd
  );

  sahs_datapath #(
    .MAX_BUCKETS(MAX_BUCKETS), .CW(COORD_WIDTH), .EW(ENTRY_INDEX_WIDTH)
  ) u_dp (
    .clk, .rst, .cmd, .status, .in_lo, .in_hi, .in_empty(bucket_empty),
    .in_entry(first_entry), .split_entry, .split_found, .u_lo, .u_hi, .best_cost
  );
endmodule

@@ tb/sv/sah_split_cost_sweep_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sah_split_cost_sweep: drives bucket sets, predicts the
// best split from its own sweep model and checks each result transaction.
// Depends only on the RTL of sah_split_cost_sweep.
module sah_split_cost_sweep_tb;

  localparam int NB = 64;
  localparam logic [42:0] COST_SAT = {43{1'b1}};
  localparam int LIMIT = 2000000;

  typedef struct {
    logic signed [15:0] lo [3];
    logic signed [15:0] hi [3];
    logic               empty;
    logic [15:0]        entry;
    logic               last;
  } bucket_t;

  typedef struct {
    logic [15:0]        entry;
    logic               found;
    logic signed [15:0] lo [3];
    logic signed [15:0] hi [3];
    logic [42:0]        cost;
  } split_t;

  typedef struct {
    logic signed [15:0] lo [3];
    logic signed [15:0] hi [3];
    logic               empty;
  } aabb_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  logic signed [15:0] box_min_x = 0, box_min_y = 0, box_min_z = 0;
  logic signed [15:0] box_max_x = 0, box_max_y = 0, box_max_z = 0;
  logic bucket_empty = 0, last_bucket = 0;
  logic [15:0] first_entry = 0;
  logic [15:0] split_entry;
  logic split_found;
  logic signed [15:0] union_min_x, union_min_y, union_min_z;
  logic signed [15:0] union_max_x, union_max_y, union_max_z;
  logic [42:0] best_cost;

  sah_split_cost_sweep dut (.*);

  bucket_t pending_buckets[$];
  split_t  expected_splits[$];
  bucket_t loaded[$];
  int errors = 0, cycles = 0, sets_checked = 0, buckets_sent = 0;
  int send_idle = 0, recv_stall = 0;
  int phase_idle [4] = '{0, 81, 0, 7};
  int phase_stall [4] = '{0, 0, 81, 7};

  // in_stall_q is low only when the last edge accepted the presented transaction.
  logic in_stall_q = 1;

  initial forever #5 clk = ~clk;

  function automatic aabb_t merge(aabb_t a, aabb_t b);
    aabb_t r;
    if (a.empty) return b;
    if (b.empty) return a;
    r.empty = 0;
    for (int k = 0; k < 3; k++) begin
      r.lo[k] = a.lo[k] < b.lo[k] ? a.lo[k] : b.lo[k];
      r.hi[k] = a.hi[k] > b.hi[k] ? a.hi[k] : b.hi[k];
    end
    return r;
  endfunction

  function automatic logic [63:0] surface(aabb_t b);
    logic [63:0] e [3];
    if (b.empty) return 0;
    for (int k = 0; k < 3; k++)
      e[k] = (b.hi[k] > b.lo[k]) ? 64'(int'(b.hi[k]) - int'(b.lo[k])) : 64'd0;
    return 2 * (e[0] * e[1] + e[1] * e[2] + e[2] * e[0]);
  endfunction

  function automatic aabb_t to_aabb(bucket_t b);
    aabb_t r;
    r.lo = b.lo;
    r.hi = b.hi;
    r.empty = b.empty;
    return r;
  endfunction

  // Accepts one bucket transaction; on the last one, sweeps and queues the split.
  task automatic predict_split(bucket_t b);
    aabb_t sfx [NB];
    aabb_t acc, pre, best_box, right;
    split_t r;
    logic [63:0] c;
    logic [42:0] best;
    bit found;
    int n;
    if (loaded.size() < NB) loaded = {loaded, b};
    if (!b.last) return;
    n = loaded.size();
    acc.empty = 1;
    for (int k = 0; k < 3; k++) begin acc.lo[k] = 0; acc.hi[k] = 0; end
    for (int i = n - 1; i >= 0; i--) begin
      acc = merge(to_aabb(loaded[i]), acc);
      sfx[i] = acc;
    end
    found = 0;
    best = COST_SAT;
    best_box = acc;
    r.entry = 0;
    if (n >= 2) begin
      pre = to_aabb(loaded[0]);
      for (int i = 0; i + 1 < n; i++) begin
        right = sfx[i + 1];
        c = surface(pre) * (i + 1) + surface(right) * (n - i - 1);
        if (c > 64'(COST_SAT)) c = 64'(COST_SAT);
        if (!found || c[42:0] < best) begin
          found = 1;
          best = c[42:0];
          r.entry = loaded[i + 1].entry;
          best_box = merge(pre, right);
        end
        pre = merge(pre, to_aabb(loaded[i + 1]));
      end
    end
    r.found = found;
    r.cost = best;
    for (int k = 0; k < 3; k++) begin
      r.lo[k] = (found && !best_box.empty) ? best_box.lo[k] : 16'sd0;
      r.hi[k] = (found && !best_box.empty) ? best_box.hi[k] : 16'sd0;
    end
    expected_splits = {expected_splits, r};
    loaded.delete();
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %0s at cycle %0d: got %0h expected %0h", what, cycles, got, want);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 40)) - 16'sd20;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_bucket(bit last, bit empty, bit wide);
    bucket_t b;
    for (int k = 0; k < 3; k++) begin
      b.lo[k] = rand_coord();
      b.hi[k] = rand_coord();
      if (!wide && $urandom_range(0, 3) != 0 && b.hi[k] < b.lo[k]) begin
        b.hi[k] = b.lo[k] ^ b.hi[k];
        b.lo[k] = b.lo[k] ^ b.hi[k];
        b.hi[k] = b.lo[k] ^ b.hi[k];
      end
    end
    b.empty = empty;
    b.entry = 16'($urandom);
    b.last = last;
    pending_buckets = {pending_buckets, b};
  endtask

  task automatic add_set(int n, int empty_pct);
    for (int i = 0; i < n; i++)
      add_bucket(i == n - 1, $urandom_range(0, 99) < empty_pct, 0);
  endtask

  // Driver: presents queued buckets, holds a stalled payload steady.
  always @(negedge clk) begin
    bucket_t b;
    bit      held;
    if (!rst) begin
      held = in_valid && in_stall_q;
      if (!held) begin
        if (pending_buckets.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          b = pending_buckets.pop_front();
          box_min_x <= b.lo[0]; box_min_y <= b.lo[1]; box_min_z <= b.lo[2];
          box_max_x <= b.hi[0]; box_max_y <= b.hi[1]; box_max_z <= b.hi[2];
          bucket_empty <= b.empty;
          first_entry <= b.entry;
          last_bucket <= b.last;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_stall_q <= 1;
    end else begin
      cycles++;
      in_stall_q <= in_valid ? in_stall : 1'b1;
      if (in_valid && !in_stall) begin
        bucket_t b;
        b.lo[0] = box_min_x; b.lo[1] = box_min_y; b.lo[2] = box_min_z;
        b.hi[0] = box_max_x; b.hi[1] = box_max_y; b.hi[2] = box_max_z;
        b.empty = bucket_empty;
        b.entry = first_entry;
        b.last = last_bucket;
        buckets_sent++;
        predict_split(b);
      end
      if (out_valid && !out_stall) begin
        if (expected_splits.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          split_t e;
          e = expected_splits.pop_front();
          sets_checked++;
          if (split_entry !== e.entry) report("split_entry", split_entry, e.entry);
          if (split_found !== e.found) report("split_found", split_found, e.found);
          if (union_min_x !== e.lo[0]) report("union_min_x", union_min_x, e.lo[0]);
          if (union_min_y !== e.lo[1]) report("union_min_y", union_min_y, e.lo[1]);
          if (union_min_z !== e.lo[2]) report("union_min_z", union_min_z, e.lo[2]);
          if (union_max_x !== e.hi[0]) report("union_max_x", union_max_x, e.hi[0]);
          if (union_max_y !== e.hi[1]) report("union_max_y", union_max_y, e.hi[1]);
          if (union_max_z !== e.hi[2]) report("union_max_z", union_max_z, e.hi[2]);
          if (best_cost !== e.cost) report("best_cost", best_cost, e.cost);
        end
      end
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 expected_splits.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    // Directed: single bucket, single empty, two buckets at extremes, all-empty set,
    // inverted and huge boxes, a set of five, overflow of 64.
    add_set(1, 0);
    add_bucket(1, 1, 0);
    begin
      bucket_t b;
      for (int k = 0; k < 3; k++) begin b.lo[k] = 16'sh8000; b.hi[k] = 16'sh7fff; end
      b.empty = 0; b.entry = 16'hffff; b.last = 0;
      pending_buckets = {pending_buckets, b};
      for (int k = 0; k < 3; k++) begin b.lo[k] = 16'sh7fff; b.hi[k] = 16'sh8000; end
      b.entry = 16'h0000; b.last = 1;
      pending_buckets = {pending_buckets, b};
    end
    add_set(3, 100);
    for (int i = 0; i < 4; i++) add_bucket(i == 3, 0, 1);
    add_set(5, 0);
    for (int i = 0; i < 70; i++) add_bucket(i == 69, i % 9 == 0, 0);
    while (pending_buckets.size() > 0 || expected_splits.size() > 0) @(posedge clk);
    for (int p = 0; p < 4; p++) begin
      int sent;
      send_idle = phase_idle[p];
      recv_stall = phase_stall[p];
      sent = 0;
      while (sent < 190) begin
        int n;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 8);
        add_set(n, $urandom_range(0, 3) == 0 ? 50 : 10);
        sent += n;
      end
      while (pending_buckets.size() > 0) @(posedge clk);
    end
    while (expected_splits.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("covered %0d bucket transactions in %0d sweeps over %0d cycles,",
             buckets_sent, sets_checked, cycles);
    $display("with sender gaps and receiver stalls in separate and joint phases");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
